// File: rtl/core/rwta_pkg.sv
// Shared types and constants for the replay window admission block.
package rwta_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_NOT_WITNESS = 2'd0;
    localparam status_t STATUS_VALID       = 2'd1;
    localparam status_t STATUS_AUTH_FAIL   = 2'd2;
    localparam status_t STATUS_REPLAY      = 2'd3;

    localparam logic [7:0] WITNESS_LEN = 8'd35;
    localparam int unsigned SEQ_W = 32;
    localparam int unsigned ID_W  = 64;

endpackage

// File: rtl/core/replay_window_table_admit.sv
// Witness packet admission: pair table search and per-pair anti-replay window.
// Header or auth rejects go straight to the result; a hit reads the window entry, then checks it;
// a miss allocates a new entry and checks a fresh window; a miss with the table full gives AUTH_FAIL.
// Flow: one item at a time; one key read a cycle while entries remain to be searched.
// s_ready is high only when no item is at work; a result may wait in m_status meanwhile.
// Reset (aresetn low, synchronous) empties the table and clears the option code.
module replay_window_table_admit #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned WINDOW_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_option_type_field,
    input  logic [7:0]           s_option_length_field,
    input  logic                 s_peer_known,
    input  logic                 s_mac_ok,
    input  logic [63:0]          s_source_id,
    input  logic [63:0]          s_destination_id,
    input  logic [31:0]          s_sequence_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rwta_pkg::status_t    m_status
);
    import rwta_pkg::*;

    localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SH_W  = $clog2(WINDOW_BITS);
    localparam int unsigned KEY_W = 2 * ID_W;
    localparam int unsigned WIN_W = SEQ_W + WINDOW_BITS;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEARCH   = 3'd1;
    localparam logic [2:0] ST_WIN_RD   = 3'd2;
    localparam logic [2:0] ST_WIN_CALC = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [WIN_W-1:0] win_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] key_q;
    logic [WIN_W-1:0] win_q;

    logic [2:0]       state_reg, state_next;
    logic [7:0]       code_reg;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic             fresh_reg, fresh_next;
    status_t          status_reg, status_next;
    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg, m_status_next;
    logic [ID_W-1:0]  src_reg, src_next;
    logic [ID_W-1:0]  dst_reg, dst_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;

    logic             hit;
    logic             key_rd_en;
    logic             key_we;
    logic             win_we;

    logic [SEQ_W-1:0]       win_top;
    logic [WINDOW_BITS-1:0] win_map;
    logic [SEQ_W-1:0]       adv;
    logic [SEQ_W-1:0]       age;
    logic [WINDOW_BITS-1:0] age_bit;
    logic [WINDOW_BITS-1:0] new_map;
    logic [SEQ_W-1:0]       new_top;
    logic                   fresh_seq;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign hit      = cmp_vld_reg && (key_q == {src_reg, dst_reg});

    // window check on the entry read back (a new entry starts at zero)
    always_comb begin
        win_top = fresh_reg ? '0 : win_q[WIN_W-1 -: SEQ_W];
        win_map = fresh_reg ? '0 : win_q[WINDOW_BITS-1:0];
        adv     = seq_reg - win_top;
        age     = win_top - seq_reg;
        age_bit = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << age[SH_W-1:0];
        new_top = win_top;
        new_map = win_map;
        fresh_seq = 1'b0;
        if (seq_reg > win_top) begin
            fresh_seq = 1'b1;
            new_top   = seq_reg;
            if (adv >= SEQ_W'(WINDOW_BITS)) begin
                new_map = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
            end else begin
                new_map = (win_map << adv[SH_W-1:0]) | {{(WINDOW_BITS-1){1'b0}}, 1'b1};
            end
        end else if (age < SEQ_W'(WINDOW_BITS) && (win_map & age_bit) == '0) begin
            fresh_seq = 1'b1;
            new_map   = win_map | age_bit;
        end
    end

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        idx_next      = idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        slot_next     = slot_reg;
        fresh_next    = fresh_reg;
        status_next   = status_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        seq_next      = seq_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        key_rd_en     = 1'b0;
        key_we        = 1'b0;
        win_we        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    src_next     = s_source_id;
                    dst_next     = s_destination_id;
                    seq_next     = s_sequence_req;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    fresh_next   = 1'b0;
                    if (s_option_type_field != code_reg
                            || s_option_length_field != WITNESS_LEN) begin
                        status_next = STATUS_NOT_WITNESS;
                        state_next  = ST_DONE;
                    end else if (!s_peer_known || !s_mac_ok) begin
                        status_next = STATUS_AUTH_FAIL;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    slot_next    = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_WIN_RD;
                end else if (idx_reg < used_reg) begin
                    key_rd_en    = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end else if (cmp_vld_reg) begin
                    cmp_vld_next = 1'b0;
                end else if (used_reg == CNT_W'(TABLE_DEPTH)) begin
                    status_next = STATUS_AUTH_FAIL;
                    state_next  = ST_DONE;
                end else begin
                    key_we     = 1'b1;
                    slot_next  = used_reg[AW-1:0];
                    used_next  = used_reg + 1'b1;
                    fresh_next = 1'b1;
                    state_next = ST_WIN_CALC;
                end
            end
            ST_WIN_RD: begin
                state_next = ST_WIN_CALC;
            end
            ST_WIN_CALC: begin
                win_we      = fresh_seq;
                status_next = fresh_seq ? STATUS_VALID : STATUS_REPLAY;
                fresh_next  = 1'b0;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            code_reg    <= '0;
            used_reg    <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            fresh_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                code_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        seq_reg      <= seq_next;
    end

    // pair keys: one read port for the search, one write on allocation
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[slot_next] <= {src_reg, dst_reg};
        end
        if (key_rd_en) begin
            key_q <= key_mem[idx_reg[AW-1:0]];
        end
    end

    // window entries: {highest sequence, seen map}
    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[slot_reg] <= {new_top, new_map};
        end
        win_q <= win_mem[slot_reg];
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("table fill count above depth");

    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("table fill count moved by more than one");

    a_slot_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WIN_CALC) |-> (CNT_W'(slot_reg) < used_reg))
        else $error("window update on an unallocated entry");

    a_done_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH && hit) |=> (state_reg == ST_WIN_RD && !cmp_vld_reg))
        else $error("search hit not followed by window read");

endmodule

// File: test/replay_window_table_admit_tb.sv
// Testbench for replay_window_table_admit: predicts each packet's status and checks every result.
`timescale 1ns / 100ps

module replay_window_table_admit_tb;
    import rwta_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int WINDOW_BITS = 64;
    localparam int POOL_SIZE   = 16;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [7:0]  otype;
        logic [7:0]  olen;
        logic        known;
        logic        mac;
        logic [63:0] src;
        logic [63:0] dst;
        logic [31:0] seq;
    } packet_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_option_type_field = 8'h00;
    logic [7:0]  s_option_length_field = 8'h00;
    logic        s_peer_known = 1'b0;
    logic        s_mac_ok = 1'b0;
    logic [63:0] s_source_id = 64'h0;
    logic [63:0] s_destination_id = 64'h0;
    logic [31:0] s_sequence_req = 32'h0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    status_t     m_status;

    // predictor state
    logic [63:0] pair_src_tbl [TABLE_DEPTH];
    logic [63:0] pair_dst_tbl [TABLE_DEPTH];
    logic [31:0] pair_top_tbl [TABLE_DEPTH];
    logic [63:0] pair_map_tbl [TABLE_DEPTH];
    int          pairs_used = 0;
    logic [7:0]  witness_code = 8'h00;

    status_t     expected_status[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    status_t     want;
    packet_t     accepted_packet;

    // stimulus state
    logic [63:0] pool_src [POOL_SIZE];
    logic [63:0] pool_dst [POOL_SIZE];
    logic [31:0] hint_top [POOL_SIZE];
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    replay_window_table_admit #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .WINDOW_BITS(WINDOW_BITS)
    ) dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_wr_data           (cfg_wr_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_option_type_field   (s_option_type_field),
        .s_option_length_field (s_option_length_field),
        .s_peer_known          (s_peer_known),
        .s_mac_ok              (s_mac_ok),
        .s_source_id           (s_source_id),
        .s_destination_id      (s_destination_id),
        .s_sequence_req        (s_sequence_req),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic status_t predict_admission(packet_t p);
        int          slot;
        int          i;
        logic [31:0] adv;
        logic [31:0] age;
        slot = -1;
        if (p.otype != witness_code || p.olen != WITNESS_LEN)
            return STATUS_NOT_WITNESS;
        if (!p.known || !p.mac)
            return STATUS_AUTH_FAIL;
        for (i = 0; i < pairs_used; i++) begin
            if (slot < 0 && pair_src_tbl[i] == p.src && pair_dst_tbl[i] == p.dst)
                slot = i;
        end
        if (slot < 0) begin
            if (pairs_used >= TABLE_DEPTH)
                return STATUS_AUTH_FAIL;
            slot = pairs_used;
            pairs_used++;
            pair_src_tbl[slot] = p.src;
            pair_dst_tbl[slot] = p.dst;
            pair_top_tbl[slot] = 32'h0;
            pair_map_tbl[slot] = 64'h0;
        end
        if (p.seq > pair_top_tbl[slot]) begin
            adv = p.seq - pair_top_tbl[slot];
            if (adv >= WINDOW_BITS)
                pair_map_tbl[slot] = 64'h1;
            else
                pair_map_tbl[slot] = (pair_map_tbl[slot] << adv) | 64'h1;
            pair_top_tbl[slot] = p.seq;
            return STATUS_VALID;
        end
        age = pair_top_tbl[slot] - p.seq;
        if (age >= WINDOW_BITS)
            return STATUS_REPLAY;
        if (pair_map_tbl[slot][age[5:0]])
            return STATUS_REPLAY;
        pair_map_tbl[slot][age[5:0]] = 1'b1;
        return STATUS_VALID;
    endfunction

    // checks results, predicts accepted items, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $error("status: result %0d with no item pending", m_status);
                    mismatch_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (m_status !== want) begin
                        $error("status: expected %0d, actual %0d", want, m_status);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                accepted_packet.otype = s_option_type_field;
                accepted_packet.olen  = s_option_length_field;
                accepted_packet.known = s_peer_known;
                accepted_packet.mac   = s_mac_ok;
                accepted_packet.src   = s_source_id;
                accepted_packet.dst   = s_destination_id;
                accepted_packet.seq   = s_sequence_req;
                expected_status.push_back(predict_admission(accepted_packet));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL replay_window_table_admit");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn || !idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic packet_t witness_packet(int idx, logic [31:0] seq);
        packet_t p;
        p.otype = witness_code;
        p.olen  = WITNESS_LEN;
        p.known = 1'b1;
        p.mac   = 1'b1;
        p.src   = pool_src[idx];
        p.dst   = pool_dst[idx];
        p.seq   = seq;
        if (seq > hint_top[idx])
            hint_top[idx] = seq;
        return p;
    endfunction

    // valid stays high across back-to-back items; lowered only for a gap or a drain
    task automatic send_packet(packet_t p);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid               <= 1'b1;
        s_option_type_field   <= p.otype;
        s_option_length_field <= p.olen;
        s_peer_known          <= p.known;
        s_mac_ok              <= p.mac;
        s_source_id           <= p.src;
        s_destination_id      <= p.dst;
        s_sequence_req        <= p.seq;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_status.size() != 0);
    endtask

    task automatic write_option_code(logic [7:0] code);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        witness_code = code;
    endtask

    // header and auth checks, with the option code still at its reset value
    task automatic test_header_checks();
        packet_t p;
        send_packet(witness_packet(0, 32'd0));  // new pair, number 0 admitted once
        send_packet(witness_packet(0, 32'd0));
        p = witness_packet(0, 32'd1);
        p.olen = 8'd34;
        send_packet(p);
        p.olen = 8'hFF;
        send_packet(p);
        p = witness_packet(0, 32'd1);
        p.otype = 8'd1;
        send_packet(p);
        p = witness_packet(0, 32'd1);
        p.known = 1'b0;
        send_packet(p);
        p.known = 1'b1;
        p.mac = 1'b0;
        send_packet(p);
        p = witness_packet(0, 32'd1);
        p.otype = 8'hFF;  // header rejects before auth
        p.known = 1'b0;
        p.mac = 1'b0;
        send_packet(p);
    endtask

    task automatic test_window_edges();
        send_packet(witness_packet(1, 32'hFFFF_FFFF));
        send_packet(witness_packet(1, 32'hFFFF_FFFF));
        send_packet(witness_packet(1, 32'hFFFF_FFC0));  // oldest in window
        send_packet(witness_packet(1, 32'hFFFF_FFBF));  // just past window
        send_packet(witness_packet(1, 32'hFFFF_FFC0));
        send_packet(witness_packet(2, 32'd5));
        send_packet(witness_packet(2, 32'd3));
        send_packet(witness_packet(2, 32'd3));
        send_packet(witness_packet(2, 32'd69));  // full-window jump
        send_packet(witness_packet(2, 32'd6));
        send_packet(witness_packet(2, 32'd5));
        send_packet(witness_packet(2, 32'd70));
        send_packet(witness_packet(2, 32'd6));
        send_packet(witness_packet(3, 32'd1));   // same source, other destination
        send_packet(witness_packet(4, 32'd1));   // other source, same destination
    endtask

    task automatic test_table_full();
        packet_t p;
        int      n;
        int      i;
        n = TABLE_DEPTH - pairs_used + 1;
        for (i = 0; i < n; i++) begin
            p = witness_packet(0, 32'd1);
            p.src = {$urandom, $urandom};
            p.dst = {$urandom, $urandom};
            p.seq = $urandom;
            send_packet(p);
        end
        send_packet(witness_packet(0, hint_top[0] + 32'd1));
    endtask

    task automatic run_random_traffic(int count);
        packet_t     p;
        int          pick;
        int          mode;
        int          idx;
        logic [31:0] top;
        logic [31:0] seq;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            mode = $urandom_range(0, 99);
            idx  = $urandom_range(0, POOL_SIZE - 1);
            top  = hint_top[idx];
            if (mode < 40)
                seq = top + $urandom_range(1, 8);
            else if (mode < 58)
                seq = top - $urandom_range(0, 70);
            else if (mode < 70)
                seq = top + $urandom_range(60, 70);
            else if (mode < 78)
                seq = top + $urandom_range(64, 32'h00FF_FFFF);
            else if (mode < 81)
                seq = $urandom;
            else
                seq = top - $urandom_range(0, 20);
            p = witness_packet(idx, seq);
            if (pick < 8) begin
                p.otype = 8'($urandom);
                if ($urandom_range(0, 1))
                    p.olen = 8'($urandom);
            end else if (pick < 14) begin
                p.known = 1'($urandom_range(0, 1));
                p.mac = p.known ? 1'b0 : 1'($urandom_range(0, 1));
            end else if (pick < 18 && n >= 150) begin
                p.src = {$urandom, $urandom};
                p.dst = {$urandom, $urandom};
            end
            send_packet(p);
        end
    endtask

    initial begin
        pool_src[0] = 64'h0;
        pool_dst[0] = 64'h0;
        pool_src[1] = '1;
        pool_dst[1] = '1;
        pool_src[2] = 64'h0123_4567_89AB_CDEF;
        pool_dst[2] = 64'hFEDC_BA98_7654_3210;
        pool_src[3] = 64'h0123_4567_89AB_CDEF;
        pool_dst[3] = 64'h5A5A_A5A5_0F0F_F0F0;
        pool_src[4] = 64'h5A5A_A5A5_0F0F_F0F0;
        pool_dst[4] = 64'hFEDC_BA98_7654_3210;
        for (int i = 0; i < POOL_SIZE; i++) begin
            hint_top[i] = 32'h0;
            if (i > 4) begin
                pool_src[i] = {$urandom, $urandom};
                pool_dst[i] = {$urandom, $urandom};
            end
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_header_checks();
        wait_for_results();
        write_option_code(8'hFF);
        test_window_edges();
        wait_for_results();
        write_option_code(8'($urandom_range(1, 254)));
        run_random_traffic(650);
        wait_for_results();
        test_table_full();
        wait_for_results();
        write_option_code(8'h00);
        idle_on = 1'b0;
        run_random_traffic(350);
        wait_for_results();
        repeat (32) @(posedge aclk);
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("PASS replay_window_table_admit");
        else
            $display("FAIL replay_window_table_admit");
        $finish;
    end

endmodule
